[rtl/lra_pkg.sv]
`default_nettype none

package lra_pkg;

   localparam int unsigned ADDR_W          = 32;
   localparam int unsigned WAY_FIELD_W     = 2;
   localparam int unsigned SET_OUT_W       = 4;
   localparam int unsigned VICTIM_W        = 2;
   localparam int unsigned AGE_W           = 31;
   localparam int unsigned STAMP_W         = 64;
   localparam int unsigned SET_MAX_W       = 10;
   localparam logic [AGE_W-1:0] AGE_LIMIT  = 31'd2147483646;

   localparam int unsigned NUM_SETS_DEF          = 16;
   localparam int unsigned NUM_WAYS_DEF          = 4;
   localparam int unsigned BLOCK_OFFSET_BITS_DEF = 5;

   typedef enum logic {
      OP_TOUCH = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                 opcode;
      logic [SET_MAX_W-1:0]   set_index;
      logic [WAY_FIELD_W-1:0] way;
   } entry_type;

endpackage

`default_nettype wire

[rtl/lra_front.sv]
`default_nettype none

module lra_front #(
   parameter int unsigned NUM_SETS          = lra_pkg::NUM_SETS_DEF,
   parameter int unsigned BLOCK_OFFSET_BITS = lra_pkg::BLOCK_OFFSET_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            clear_busy,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_opcode,
   input  wire logic [lra_pkg::ADDR_W-1:0]      req_address,
   input  wire logic [lra_pkg::WAY_FIELD_W-1:0] req_way,
   output logic                                 push_valid,
   input  wire logic                            push_ready,
   output lra_pkg::entry_type                   push_entry
);

   localparam int unsigned VAL_W = lra_pkg::ADDR_W - BLOCK_OFFSET_BITS;

   logic [lra_pkg::ADDR_W-1:0] shifted;

   assign shifted = req_address >> BLOCK_OFFSET_BITS;

   if ((NUM_SETS & (NUM_SETS - 1)) == 0) begin : g_mask

      logic               out_valid_ff;
      lra_pkg::entry_type entry_ff;
      lra_pkg::entry_type entry_in;
      logic               take;

      assign req_ready = !clear_busy && (!out_valid_ff || push_ready);
      assign take      = req_valid && req_ready;

      always_comb begin
         entry_in.opcode    = lra_pkg::op_type'(req_opcode);
         entry_in.set_index = lra_pkg::SET_MAX_W'(shifted & lra_pkg::ADDR_W'(NUM_SETS - 1));
         entry_in.way       = req_way;
      end

      always_ff @(posedge clock) begin
         if (take) begin
            entry_ff <= entry_in;
         end
         if (reset) begin
            out_valid_ff <= 1'b0;
         end else if (take) begin
            out_valid_ff <= 1'b1;
         end else if (push_ready) begin
            out_valid_ff <= 1'b0;
         end
      end

      assign push_valid = out_valid_ff;
      assign push_entry = entry_ff;

   end else begin : g_divide

      // A reciprocal multiplication in state F_MUL gives the quotient, and a subtraction in
      // F_SUB gives the remainder from it.
      localparam int unsigned LOG_W  = $clog2(NUM_SETS);
      localparam int unsigned SHIFT  = VAL_W + LOG_W;
      localparam int unsigned RCP_W  = VAL_W + 1;
      localparam int unsigned PROD_W = VAL_W + RCP_W;
      localparam logic [63:0] RECIP_WIDE =
         ((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
      localparam logic [RCP_W-1:0] RECIP = RECIP_WIDE[RCP_W-1:0];

      typedef enum logic [1:0] {
         F_IDLE,
         F_MUL,
         F_SUB,
         F_HOLD
      } state_type;

      state_type                         state_ff, state_in;
      logic [VAL_W-1:0]                  value_ff, value_in;
      logic [PROD_W-1:0]                 prod_ff, prod_in;
      logic [VAL_W-1:0]                  rem_ff, rem_in;
      lra_pkg::op_type                   opcode_ff, opcode_in;
      logic [lra_pkg::WAY_FIELD_W-1:0]   way_ff, way_in;
      logic [VAL_W-1:0]                  quotient;

      assign req_ready = (state_ff == F_IDLE) && !clear_busy;
      assign quotient  = VAL_W'(prod_ff >> SHIFT);

      always_comb begin
         state_in  = state_ff;
         value_in  = value_ff;
         prod_in   = prod_ff;
         rem_in    = rem_ff;
         opcode_in = opcode_ff;
         way_in    = way_ff;
         case (state_ff)
            F_IDLE: begin
               if (req_valid && req_ready) begin
                  value_in  = shifted[VAL_W-1:0];
                  opcode_in = lra_pkg::op_type'(req_opcode);
                  way_in    = req_way;
                  state_in  = F_MUL;
               end
            end
            F_MUL: begin
               prod_in  = PROD_W'(value_ff) * PROD_W'(RECIP);
               state_in = F_SUB;
            end
            F_SUB: begin
               rem_in   = value_ff - quotient * VAL_W'(NUM_SETS);
               state_in = F_HOLD;
            end
            F_HOLD: begin
               if (push_ready) begin
                  state_in = F_IDLE;
               end
            end
            default: begin
               state_in = F_IDLE;
            end
         endcase
      end

      always_ff @(posedge clock) begin
         value_ff  <= value_in;
         prod_ff   <= prod_in;
         rem_ff    <= rem_in;
         opcode_ff <= opcode_in;
         way_ff    <= way_in;
         if (reset) begin
            state_ff <= F_IDLE;
         end else begin
            state_ff <= state_in;
         end
      end

      assign push_valid           = (state_ff == F_HOLD);
      assign push_entry.opcode    = opcode_ff;
      assign push_entry.set_index = lra_pkg::SET_MAX_W'(rem_ff);
      assign push_entry.way       = way_ff;

   end

endmodule

`default_nettype wire

[rtl/lra_queue.sv]
`default_nettype none

module lra_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire lra_pkg::entry_type  push_entry,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output lra_pkg::entry_type       pop_entry
);

   localparam int unsigned DEPTH = 2;

   lra_pkg::entry_type entry_ff [DEPTH];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               push_fire;
   logic               pop_fire;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/lra_back.sv]
`default_nettype none

module lra_back #(
   parameter int unsigned NUM_SETS = lra_pkg::NUM_SETS_DEF,
   parameter int unsigned NUM_WAYS = lra_pkg::NUM_WAYS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   output logic                               clear_busy,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire lra_pkg::entry_type            pop_entry,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [lra_pkg::SET_OUT_W-1:0]      rsp_set_index,
   output logic [lra_pkg::VICTIM_W-1:0]       rsp_victim_way
);

   localparam int unsigned SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int unsigned WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int unsigned CNT_W   = $clog2(NUM_WAYS + 1);
   localparam int unsigned AGE_W   = lra_pkg::AGE_W;
   localparam int unsigned STAMP_W = lra_pkg::STAMP_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Each entry holds the touch count at which that way was last used; its age is the
   // distance to the current touch count, saturated.
   logic [STAMP_W-1:0] stamp_mem [NUM_SETS][NUM_WAYS];
   logic [STAMP_W-1:0] rd_data_ff;

   state_type                       state_ff, state_in;
   logic [SET_W-1:0]                clr_set_ff, clr_set_in;
   logic [WAY_W-1:0]                clr_way_ff, clr_way_in;
   logic [STAMP_W-1:0]              now_ff, now_in;
   logic [SET_W-1:0]                set_ff, set_in;
   logic [CNT_W-1:0]                rd_cnt_ff, rd_cnt_in;
   logic                            rd_v_ff, rd_v_in;
   logic [WAY_W-1:0]                rd_way_ff, rd_way_in;
   logic                            age_v_ff, age_v_in;
   logic [WAY_W-1:0]                age_way_ff, age_way_in;
   logic [AGE_W-1:0]                age_ff, age_in;
   logic [AGE_W-1:0]                best_age_ff, best_age_in;
   logic [WAY_W-1:0]                best_way_ff, best_way_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lra_pkg::SET_OUT_W-1:0]   rsp_set_ff, rsp_set_in;
   logic [lra_pkg::VICTIM_W-1:0]    rsp_victim_ff, rsp_victim_in;

   logic                            slot_free;
   logic                            pop_fire;
   logic                            way_ok;
   logic                            mem_we;
   logic [SET_W-1:0]                wr_set;
   logic [WAY_W-1:0]                wr_way;
   logic [STAMP_W-1:0]              wr_data;
   logic [STAMP_W-1:0]              diff;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready  = (state_ff == ST_IDLE) && slot_free;
   assign pop_fire   = pop_valid && pop_ready;
   assign way_ok     = (32'(pop_entry.way) < NUM_WAYS);
   assign clear_busy = (state_ff == ST_CLEAR);
   assign diff       = now_ff - rd_data_ff;

   always_comb begin
      if (diff >= STAMP_W'(lra_pkg::AGE_LIMIT)) begin
         age_in = lra_pkg::AGE_LIMIT;
      end else begin
         age_in = AGE_W'(diff);
      end
   end

   always_comb begin
      mem_we  = 1'b0;
      wr_set  = clr_set_ff;
      wr_way  = clr_way_ff;
      wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            if (pop_fire && (pop_entry.opcode == lra_pkg::OP_TOUCH) && way_ok) begin
               mem_we  = 1'b1;
               wr_set  = SET_W'(pop_entry.set_index);
               wr_way  = WAY_W'(pop_entry.way);
               wr_data = now_ff + 1'b1;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[wr_set][wr_way] <= wr_data;
      end
      rd_data_ff <= stamp_mem[set_ff][rd_cnt_ff[WAY_W-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      clr_set_in    = clr_set_ff;
      clr_way_in    = clr_way_ff;
      now_in        = now_ff;
      set_in        = set_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_v_in       = 1'b0;
      rd_way_in     = rd_way_ff;
      age_v_in      = 1'b0;
      age_way_in    = rd_way_ff;
      best_age_in   = best_age_ff;
      best_way_in   = best_way_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_set_in    = rsp_set_ff;
      rsp_victim_in = rsp_victim_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_way_ff == WAY_W'(NUM_WAYS - 1)) begin
               clr_way_in = '0;
               clr_set_in = clr_set_ff + 1'b1;
               if (clr_set_ff == SET_W'(NUM_SETS - 1)) begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_way_in = clr_way_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (pop_fire) begin
               if (pop_entry.opcode == lra_pkg::OP_TOUCH) begin
                  now_in        = now_ff + 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_set_in    = lra_pkg::SET_OUT_W'(pop_entry.set_index);
                  rsp_victim_in = '0;
               end else begin
                  set_in      = SET_W'(pop_entry.set_index);
                  rd_cnt_in   = '0;
                  best_age_in = '0;
                  best_way_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_cnt_ff < CNT_W'(NUM_WAYS)) begin
               rd_v_in   = 1'b1;
               rd_way_in = rd_cnt_ff[WAY_W-1:0];
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            age_v_in = rd_v_ff;
            if (age_v_ff) begin
               if (age_ff > best_age_ff) begin
                  best_age_in = age_ff;
                  best_way_in = age_way_ff;
               end
               if (age_way_ff == WAY_W'(NUM_WAYS - 1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_set_in    = lra_pkg::SET_OUT_W'(set_ff);
               rsp_victim_in = lra_pkg::VICTIM_W'(best_way_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      set_ff        <= set_in;
      rd_way_ff     <= rd_way_in;
      age_way_ff    <= age_way_in;
      age_ff        <= age_in;
      best_age_ff   <= best_age_in;
      best_way_ff   <= best_way_in;
      rsp_set_ff    <= rsp_set_in;
      rsp_victim_ff <= rsp_victim_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_set_ff   <= '0;
         clr_way_ff   <= '0;
         now_ff       <= '0;
         rd_cnt_ff    <= '0;
         rd_v_ff      <= 1'b0;
         age_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_set_ff   <= clr_set_in;
         clr_way_ff   <= clr_way_in;
         now_ff       <= now_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_v_ff      <= rd_v_in;
         age_v_ff     <= age_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_set_index  = rsp_set_ff;
   assign rsp_victim_way = rsp_victim_ff;

endmodule

`default_nettype wire

[rtl/lru_age_replacement.sv]
// Age-based LRU replacement policy for a set-associative cache.
// Request channel (req_): opcode 0 marks a way of the set as used, opcode 1 asks for the
// victim way of the set; the set comes from the address bits above the block offset.
// Response channel (rsp_): one beat for every request beat, in order, carrying the set
// index and, for a query, the way of the set with the largest age (lowest way on a tie).
// The front stage derives the set index: with a registered mask for a power-of-two set
// count, and otherwise through the states F_MUL and F_SUB, where a reciprocal
// multiplication and a subtraction give the remainder. A two-entry queue separates it
// from the back end, which holds the ages. The back end handles a touch in ST_IDLE, so
// with a power-of-two set count touches stream at one beat per cycle while the receiver
// takes them. A query scans the set one way per cycle through the single read port of
// the age store, and the back end takes no other entry until ST_FINISH answers it.
// After reset the back end clears all NUM_SETS * NUM_WAYS entries (64 by default) of the
// age store, one entry per cycle; req_ready stays low during that pass.
// When the receiver stalls, the response register holds its beat, the back end stops
// and the queue and front stage fill before req_ready drops.
`default_nettype none

module lru_age_replacement #(
   parameter int unsigned NUM_SETS          = lra_pkg::NUM_SETS_DEF,
   parameter int unsigned NUM_WAYS          = lra_pkg::NUM_WAYS_DEF,
   parameter int unsigned BLOCK_OFFSET_BITS = lra_pkg::BLOCK_OFFSET_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_opcode,
   input  wire logic [lra_pkg::ADDR_W-1:0]      req_address,
   input  wire logic [lra_pkg::WAY_FIELD_W-1:0] req_way,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [lra_pkg::SET_OUT_W-1:0]        rsp_set_index,
   output logic [lra_pkg::VICTIM_W-1:0]         rsp_victim_way
);

   logic               clear_busy;
   logic               push_valid;
   logic               push_ready;
   lra_pkg::entry_type push_entry;
   logic               pop_valid;
   logic               pop_ready;
   lra_pkg::entry_type pop_entry;

   lra_front #(
      .NUM_SETS          (NUM_SETS),
      .BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .clear_busy  (clear_busy),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_address (req_address),
      .req_way     (req_way),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   lra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   lra_back #(
      .NUM_SETS (NUM_SETS),
      .NUM_WAYS (NUM_WAYS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .clear_busy     (clear_busy),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_set_index  (rsp_set_index),
      .rsp_victim_way (rsp_victim_way)
   );

endmodule

`default_nettype wire

[rtl/lra_checker.sv]
`default_nettype none

module lra_checker #(
   parameter int unsigned NUM_SETS = lra_pkg::NUM_SETS_DEF,
   parameter int unsigned NUM_WAYS = lra_pkg::NUM_WAYS_DEF
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [lra_pkg::SET_OUT_W-1:0]        rsp_set_index,
   input wire logic [lra_pkg::VICTIM_W-1:0]         rsp_victim_way
);

   logic [3:0] pending_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         pending_ff <= pending_ff + 4'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_ff <= pending_ff - 4'd1;
      end
   end

   // A response beat always answers a request beat that is still outstanding.
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response beat without an outstanding request");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_set_index)
                                  && $stable(rsp_victim_way))
      else $error("stalled response beat changed");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((NUM_SETS > 16) || (32'(rsp_set_index) < NUM_SETS))
                    && ((NUM_WAYS > 4) || (32'(rsp_victim_way) < NUM_WAYS)))
      else $error("response set or way out of range");

endmodule

bind lru_age_replacement lra_checker #(
   .NUM_SETS (NUM_SETS),
   .NUM_WAYS (NUM_WAYS)
) u_lra_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_set_index  (rsp_set_index),
   .rsp_victim_way (rsp_victim_way)
);

`default_nettype wire

[tb/lru_tracker_pkg.sv]
`timescale 1ns / 100ps

package lru_tracker_pkg;

   import lra_pkg::*;

   class lru_tracker;

      typedef struct packed {
         logic [SET_OUT_W-1:0] set_index;
         logic [VICTIM_W-1:0]  victim_way;
      } reply_type;

      int unsigned age [NUM_SETS_DEF][NUM_WAYS_DEF];
      reply_type   replies_due [$];
      int          errors;
      int          touches;
      int          queries;

      function new();
         foreach (age[s, w]) begin
            age[s][w] = 0;
         end
         errors  = 0;
         touches = 0;
         queries = 0;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function void record_request(op_type op, logic [ADDR_W-1:0] address,
                                   logic [WAY_FIELD_W-1:0] way);
         int unsigned line_set;
         int unsigned oldest;
         int unsigned oldest_age;
         reply_type   reply;
         line_set   = (address >> BLOCK_OFFSET_BITS_DEF) % NUM_SETS_DEF;
         oldest     = 0;
         oldest_age = 0;
         if (op == OP_TOUCH) begin
            touches++;
            foreach (age[s, w]) begin
               if (s == line_set && w == way) begin
                  age[s][w] = 0;
               end else if (age[s][w] < AGE_LIMIT) begin
                  age[s][w]++;
               end
            end
         end else begin
            queries++;
            for (int w = 0; w < NUM_WAYS_DEF; w++) begin
               if (age[line_set][w] > oldest_age) begin
                  oldest_age = age[line_set][w];
                  oldest     = w;
               end
            end
         end
         reply.set_index  = line_set[SET_OUT_W-1:0];
         reply.victim_way = oldest[VICTIM_W-1:0];
         replies_due.push_back(reply);
      endfunction

      function void check_response(logic [SET_OUT_W-1:0] set_index,
                                   logic [VICTIM_W-1:0] victim_way);
         reply_type reply;
         if (replies_due.size() == 0) begin
            $error("response beat with set_index %0d arrived with no request waiting",
                   set_index);
            errors++;
            return;
         end
         reply = replies_due.pop_front();
         if (set_index !== reply.set_index) begin
            $error("set_index: expected %0d, actual %0d", reply.set_index, set_index);
            errors++;
         end
         if (victim_way !== reply.victim_way) begin
            $error("victim_way: expected %0d, actual %0d", reply.victim_way, victim_way);
            errors++;
         end
      endfunction

   endclass

endpackage

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   import lra_pkg::*;
   import lru_tracker_pkg::*;

   localparam int RANDOM_BEATS = 650;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 2000;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic                   req_opcode     = 1'b0;
   logic [ADDR_W-1:0]      req_address    = '0;
   logic [WAY_FIELD_W-1:0] req_way        = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [SET_OUT_W-1:0]   rsp_set_index;
   logic [VICTIM_W-1:0]    rsp_victim_way;

   lru_tracker book;
   bit         calm         = 1'b0;
   bit         hold_request = 1'b0;
   int         quiet_cycles = 0;

   lru_age_replacement i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_way        (req_way),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_set_index  (rsp_set_index),
      .rsp_victim_way (rsp_victim_way)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_beat(op_type op, logic [ADDR_W-1:0] address,
                            logic [WAY_FIELD_W-1:0] way);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_address <= address;
      req_way     <= way;
      do @(posedge clock); while (!req_ready);
      book.record_request(op, address, way);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] address;
      address = $urandom;
      // Half the traffic lands in a few sets so that every way there gets reused.
      if ($urandom_range(1) == 0) begin
         address[BLOCK_OFFSET_BITS_DEF +: SET_OUT_W] = SET_OUT_W'($urandom_range(3));
      end
      return address;
   endfunction

   initial begin
      int     hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            book.check_response(rsp_set_index, rsp_victim_way);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 15);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: no beat moved for %0d cycles", QUIET_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      op_type op;
      book = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // All ages start at zero, so both ends of the address space report way 0.
      send_beat(OP_QUERY, 32'h0000_0000, 2'd0);
      send_beat(OP_QUERY, 32'hFFFF_FFFF, 2'd3);
      send_beat(OP_TOUCH, 32'h0000_001F, 2'd0);
      send_beat(OP_TOUCH, 32'h0000_0200, 2'd1);
      send_beat(OP_TOUCH, 32'hFFFF_FE00, 2'd2);
      send_beat(OP_TOUCH, 32'h8000_0000, 2'd3);
      send_beat(OP_QUERY, 32'h0000_0000, 2'd3);
      send_beat(OP_TOUCH, 32'hFFFF_FFFF, 2'd3);
      send_beat(OP_QUERY, 32'hFFFF_FFFF, 2'd0);
      send_beat(OP_TOUCH, 32'h0000_00A0, 2'd0);
      send_beat(OP_QUERY, 32'h0000_00A0, 2'd2);
      send_beat(OP_QUERY, 32'h0000_00A0, 2'd1);
      send_beat(OP_TOUCH, 32'h7FFF_FE1F, 2'd0);
      send_beat(OP_QUERY, 32'h0000_0000, 2'd0);
      send_beat(OP_TOUCH, 32'h0000_0020, 2'd2);
      send_beat(OP_TOUCH, 32'h0000_0020, 2'd2);
      send_beat(OP_QUERY, 32'h0000_0020, 2'd3);
      send_beat(OP_QUERY, 32'h5555_5555, 2'd1);
      send_beat(OP_QUERY, 32'hAAAA_AAAA, 2'd2);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         calm = (n >= 300 && n < 420);
         if (n == 200) begin
            hold_request = 1'b1;
         end
         if (n == 470) begin
            wait_drained();
         end
         op = ($urandom_range(9) < 6) ? OP_TOUCH : OP_QUERY;
         send_beat(op, pick_address(), WAY_FIELD_W'($urandom_range(3)));
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (book.pending() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("testbench: %0d touch and %0d query beats over %0d sets,",
               book.touches, book.queries, NUM_SETS_DEF);
      $display("testbench: with random stalls, a %0d-cycle response hold-off and a full drain",
               HOLD_CYCLES);
      if (book.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
